// ===== hw/rtl/trk_pkg.sv =====
// ----------------------------------------------------------------------------
// trk_pkg: shared types and constants of the top-k insertion ranker
// Transaction structs, held entry format, tag codes and board layout values.
// ----------------------------------------------------------------------------
package trk_pkg;

	localparam logic [1:0] TAG_NONE   = 2'd0;
	localparam logic [1:0] TAG_VIEWER = 2'd1;
	localparam logic [1:0] TAG_KILLER = 2'd2;

	localparam logic [2:0] COL_SPLIT   = 3'd6;
	localparam logic [7:0] COL_RIGHT_X = 8'd160;
	localparam logic [7:0] ROW_BASE    = 8'd32;

	typedef struct packed {
		logic [7:0]         player_index;
		logic signed [31:0] player_score;
		logic               is_active;
		logic               is_viewer;
		logic               is_killer;
		logic               end_of_scan;
	} item_t;

	typedef struct packed {
		logic [3:0]         rank_pos;
		logic [7:0]         ranked_index;
		logic signed [31:0] ranked_score;
		logic [1:0]         tag_kind;
		logic [7:0]         column_x;
		logic [7:0]         row_y;
		logic               last_of_run;
	} result_t;

	typedef struct packed {
		logic [7:0]         index;
		logic signed [31:0] score;
		logic [1:0]         tag;
	} entry_t;

	// per-cycle command to every cell of the chain
	typedef struct packed {
		logic insert;   // place new entry, lower ones move down one cell
		logic advance;  // whole chain moves up one cell toward the output
	} cell_ctl_t;

endpackage

// ===== hw/rtl/top_k_insertion_ranker_core.sv =====
// ----------------------------------------------------------------------------
// top_k_insertion_ranker_core: keeps the best TOP_COUNT participants
// Insertion chain ranking by descending score, emitted at end of scan.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one participant per transaction. Active items with an index
//   below MAX_PLAYERS are placed in a chain of TOP_COUNT cells, after any
//   equal score; the lowest entry falls off a full chain. One item per cycle
//   is taken while scanning, each inserted in that cycle.
//   An item with end_of_scan set is ranked first, then the chain drains up
//   through the result register, one result per cycle while result_stall
//   stays low, rank 0 first, the final one flagged last_of_run. item_stall
//   is high for the drain, also when the chain is empty (zero results).
//   The first result is loaded once the state register has entered the
//   drain state after the end_of_scan transaction.
//   result_stall freezes the result register and the drain; a new scan may
//   start while the last result still waits to be taken.
//   Reset clears all cell valid bits, the result valid and the drain state.
// ----------------------------------------------------------------------------
module top_k_insertion_ranker_core
	import trk_pkg::*;
#(
	parameter int MAX_PLAYERS = 256,
	parameter int TOP_COUNT   = 12
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	typedef enum logic {ST_SCAN, ST_DRAIN} state_t;

	state_t    state_q;
	cell_ctl_t ctl;
	entry_t    new_entry;
	entry_t    ent   [TOP_COUNT];
	logic      vld   [TOP_COUNT];
	logic      go    [TOP_COUNT];
	logic      item_acc;
	logic      free;
	logic      load;
	logic      last;

	assign item_stall = (state_q == ST_DRAIN);
	assign item_acc   = item_valid && !item_stall;

	assign new_entry.index = item.player_index;
	assign new_entry.score = item.player_score;
	assign new_entry.tag   = item.is_viewer ? TAG_VIEWER :
	                         item.is_killer ? TAG_KILLER : TAG_NONE;

	assign ctl.insert  = item_acc && item.is_active &&
	                     ({24'd0, item.player_index} < 32'(MAX_PLAYERS));
	assign load        = (state_q == ST_DRAIN) && vld[0] && free;
	assign ctl.advance = load;

	generate
		if (TOP_COUNT > 1) begin : g_last
			assign last = !vld[1];
		end else begin : g_last_one
			assign last = 1'b1;
		end
	endgenerate

	for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
		entry_t prev_e, next_e;
		logic   prev_v, prev_g, next_v;
		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_v = 1'b0;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = ent[i-1];
			assign prev_v = vld[i-1];
			assign prev_g = go[i-1];
		end
		if (i == TOP_COUNT - 1) begin : g_tail
			assign next_e = '0;
			assign next_v = 1'b0;
		end else begin : g_body
			assign next_e = ent[i+1];
			assign next_v = vld[i+1];
		end
		trk_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_valid (prev_v),
			.prev_go    (prev_g),
			.next_entry (next_e),
			.next_valid (next_v),
			.entry      (ent[i]),
			.valid      (vld[i]),
			.go         (go[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
		end else begin
			case (state_q)
				ST_SCAN: begin
					if (item_acc && item.end_of_scan) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld[0] || (load && last)) begin
						state_q <= ST_SCAN;
					end
				end
				default: state_q <= ST_SCAN;
			endcase
		end
	end

	trk_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.entry        (ent[0]),
		.last         (last),
		.result_stall (result_stall),
		.free         (free),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== hw/rtl/trk_cell.sv =====
// ----------------------------------------------------------------------------
// trk_cell: one slot of the ranking chain
// Compares the new score with its own, takes the new entry, its upper
// neighbor's entry on insert, or its lower neighbor's entry on drain.
// ----------------------------------------------------------------------------
module trk_cell
	import trk_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  entry_t    prev_entry,
	input  logic      prev_valid,
	input  logic      prev_go,
	input  entry_t    next_entry,
	input  logic      next_valid,
	output entry_t    entry,
	output logic      valid,
	output logic      go
);

	entry_t entry_q;
	logic   valid_q;

	// go marks the insertion point and every slot below it; ties stay above
	assign go    = !valid_q || (new_entry.score > entry_q.score);
	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			if (go && !prev_go) begin
				valid_q <= 1'b1;
			end else if (go) begin
				valid_q <= prev_valid;
			end
		end else if (ctl.advance) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (go && !prev_go) begin
				entry_q <= new_entry;
			end else if (go) begin
				entry_q <= prev_entry;
			end
		end else if (ctl.advance) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== hw/rtl/trk_out_stage.sv =====
// ----------------------------------------------------------------------------
// trk_out_stage: result register and board layout
// Holds one result transaction and tracks rank, row and column of the run.
// ----------------------------------------------------------------------------
module trk_out_stage
	import trk_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  entry_t  entry,
	input  logic    last,
	input  logic    result_stall,
	output logic    free,
	output logic    result_valid,
	output result_t result
);

	logic       result_valid_q;
	result_t    result_q;
	logic [3:0] rank_q;    // wraps mod 16, as rank_pos does
	logic [2:0] row_q;
	logic       right_q;

	assign free         = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			rank_q         <= '0;
			row_q          <= '0;
			right_q        <= 1'b0;
		end else begin
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (load) begin
				if (last) begin
					rank_q  <= '0;
					row_q   <= '0;
					right_q <= 1'b0;
				end else begin
					rank_q <= rank_q + 4'd1;
					if (row_q == COL_SPLIT - 3'd1) begin
						row_q   <= '0;
						right_q <= 1'b1;
					end else begin
						row_q <= row_q + 3'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.rank_pos     <= rank_q;
			result_q.ranked_index <= entry.index;
			result_q.ranked_score <= entry.score;
			result_q.tag_kind     <= entry.tag;
			result_q.column_x     <= right_q ? COL_RIGHT_X : 8'd0;
			result_q.row_y        <= ROW_BASE + {row_q, 5'b0_0000};
			result_q.last_of_run  <= last;
		end
	end

endmodule

// ===== hw/rtl/trk_checker.sv =====
// ----------------------------------------------------------------------------
// trk_checker: port-level checks of the top-k insertion ranker
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module trk_checker
	import trk_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// end of scan starts the drain, which blocks new items
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.end_of_scan |=> item_stall)
		else $error("no drain after end of scan");

	// while a result that is not the last one is shown, the run is still draining
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_run |-> item_stall)
		else $error("scan resumed before run ended");

	// tag code is never the unused value
	a_tag_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.tag_kind == TAG_NONE || result.tag_kind == TAG_VIEWER ||
		                  result.tag_kind == TAG_KILLER))
		else $error("bad tag code");

endmodule

bind top_k_insertion_ranker_core trk_checker u_trk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
